// ===== rtl/rlts_pkg.sv =====
package rlts_pkg;

  // Table sizes.
  localparam int unsigned LEVELS = 16;
  localparam int unsigned TASKS  = 64;

  // Payload field widths on the channels.
  localparam int unsigned FUNC_W    = 2;
  localparam int unsigned TASK_ID_W = 6;
  localparam int unsigned PRIO_W    = 5;

  // Internal widths derived from the table sizes.
  localparam int unsigned TASK_W   = $clog2(TASKS);
  localparam int unsigned LVL_W    = $clog2(LEVELS);
  localparam int unsigned LVLS_W   = $clog2(LEVELS + 1);
  localparam int unsigned BUDGET_W = $clog2(LEVELS + 1);

  // Command codes.
  localparam logic [FUNC_W-1:0] FUNC_SCHEDULE   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_RESCHEDULE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_BLOCK      = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_UNBLOCK    = 2'd3;

  // One list link: a valid bit and the next task index.
  typedef struct packed {
    logic              valid;
    logic [TASK_W-1:0] idx;
  } link_t;

  localparam int unsigned LINK_W = TASK_W + 1;

endpackage

// ===== rtl/rlts_cmd_if.sv =====
interface rlts_cmd_if import rlts_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [FUNC_W-1:0]    func;
  logic [TASK_ID_W-1:0] task_id;
  logic [PRIO_W-1:0]    priority_req;

  modport source (output valid, output func, output task_id, output priority_req,
                  input ready);
  modport sink   (input valid, input func, input task_id, input priority_req,
                  output ready);
endinterface

// ===== rtl/rlts_res_if.sv =====
interface rlts_res_if import rlts_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 found;
  logic [TASK_ID_W-1:0] chosen_task;

  modport source (output valid, output found, output chosen_task, input ready);
  modport sink   (input valid, input found, input chosen_task, output ready);
endinterface

// ===== rtl/rlts_ram.sv =====
module rlts_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/rotating_level_task_scheduler.sv =====
// Rotating level task scheduler.
//
// Commands arrive on cmd_i (valid/ready); a transfer carries func, task_id and
// priority_req. Every command gives exactly one result transfer on res_o with
// found and chosen_task; schedule, block and unblock always answer found = 0.
// The block works on one command at a time: cmd_i.ready is high only while it
// is idle.
// Schedule, block and unblock pass through the execute state to the done state.
// Reschedule runs the pick loop, which takes a pick and a pop state per task
// taken off level 0 and a pick state per empty level rotation. Its run time is
// bound by the single read port of the link and level RAMs, which the pick loop
// visits once per popped task.
// The next command is taken in the cycle after its predecessor's result enters
// the output register, so the block cannot take a new command before it is
// through with the last one.
// A finished result waits in a holding register while res_o is stalled; the
// block goes back to idle as soon as the output register takes it.
// Reset (rst_ni low, asynchronous) empties every level list, zeroes the
// rotation and clears all blocked and queued flags. The task link and task
// level RAMs are not cleared; no task entry is used before it is written.
module rotating_level_task_scheduler import rlts_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  rlts_cmd_if.sink   cmd_i,
  rlts_res_if.source res_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_EXEC = 3'd1;
  localparam logic [2:0] ST_PICK = 3'd2;
  localparam logic [2:0] ST_POP  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  // Physical slot of a logical level under the current rotation.
  function automatic logic [LVL_W-1:0] level_slot(input logic [LVLS_W-1:0] lvl,
                                                  input logic [LVL_W-1:0]  rot);
    logic [LVL_W:0] sum;
    sum = (LVL_W+1)'(lvl) + (LVL_W+1)'(rot);
    if (sum >= (LVL_W+1)'(LEVELS)) begin
      sum = sum - (LVL_W+1)'(LEVELS);
    end
    return sum[LVL_W-1:0];
  endfunction

  logic [2:0]          state_q, state_d;
  logic [FUNC_W-1:0]   func_q, func_d;
  logic [TASK_W-1:0]   tid_q, tid_d;
  logic                in_range_q, in_range_d;
  logic [LVLS_W-1:0]   prio_q, prio_d;
  logic [LVL_W-1:0]    rot_q, rot_d;
  logic [BUDGET_W-1:0] budget_q, budget_d;
  logic [TASK_W-1:0]   pop_task_q, pop_task_d;
  logic                res_found_q, res_found_d;
  logic [TASK_W-1:0]   res_task_q, res_task_d;

  logic                out_valid_q, out_valid_d;
  logic                out_found_q, out_found_d;
  logic [TASK_W-1:0]   out_task_q, out_task_d;

  logic [LEVELS-1:0]   head_valid_q, head_valid_d;
  logic [TASK_W-1:0]   head_idx_q [LEVELS];
  logic [TASK_W-1:0]   head_idx_d [LEVELS];
  logic [TASKS-1:0]    blocked_q, blocked_d;
  logic [TASKS-1:0]    queued_q, queued_d;
  logic [TASKS-1:0]    lvl_set_q, lvl_set_d;

  logic                cmd_xfer;
  logic                out_free;
  logic [TASK_W-1:0]   tid_in;
  logic                in_range_in;
  logic [LVLS_W-1:0]   prio_in;

  logic                push_en;
  logic [TASK_W-1:0]   push_task;
  logic [LVLS_W-1:0]   push_lvl;

  logic                link_we;
  link_t               link_wdata;
  link_t               link_rdata;
  logic [LINK_W-1:0]   link_rdata_raw;
  logic                lvl_we;
  logic [LVLS_W-1:0]   lvl_wdata;
  logic [LVLS_W-1:0]   lvl_rdata;
  logic [TASK_W-1:0]   lvl_raddr;

  // Command channel and input decoding.
  assign cmd_i.ready = (state_q == ST_IDLE);
  assign cmd_xfer    = cmd_i.valid && cmd_i.ready;
  assign out_free    = !out_valid_q || res_o.ready;
  assign tid_in      = TASK_W'(cmd_i.task_id);
  assign in_range_in = (32'(cmd_i.task_id) < TASKS);
  assign prio_in     = (32'(cmd_i.priority_req) > LEVELS) ? LVLS_W'(LEVELS)
                                                         : LVLS_W'(cmd_i.priority_req);

  // The pick loop reads the entry of the task at the head of level 0.
  assign lvl_raddr  = (state_q == ST_PICK) ? head_idx_q[rot_q] : tid_in;
  assign link_rdata = link_t'(link_rdata_raw);

  rlts_ram #(
    .WIDTH (LINK_W),
    .DEPTH (TASKS)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (push_task),
    .wdata_i (LINK_W'(link_wdata)),
    .raddr_i (head_idx_q[rot_q]),
    .rdata_o (link_rdata_raw)
  );

  rlts_ram #(
    .WIDTH (LVLS_W),
    .DEPTH (TASKS)
  ) u_level_ram (
    .clk_i   (clk_i),
    .we_i    (lvl_we),
    .waddr_i (tid_q),
    .wdata_i (lvl_wdata),
    .raddr_i (lvl_raddr),
    .rdata_o (lvl_rdata)
  );

  // Sequencer: command execution, the pick loop and the shared list push.
  always_comb begin
    logic [LVL_W-1:0] slot;
    link_t            old_head;

    state_d      = state_q;
    func_d       = func_q;
    tid_d        = tid_q;
    in_range_d   = in_range_q;
    prio_d       = prio_q;
    rot_d        = rot_q;
    budget_d     = budget_q;
    pop_task_d   = pop_task_q;
    res_found_d  = res_found_q;
    res_task_d   = res_task_q;
    head_valid_d = head_valid_q;
    head_idx_d   = head_idx_q;
    blocked_d    = blocked_q;
    queued_d     = queued_q;
    lvl_set_d    = lvl_set_q;

    push_en    = 1'b0;
    push_task  = tid_q;
    push_lvl   = '0;
    lvl_we     = 1'b0;
    lvl_wdata  = prio_q;
    link_we    = 1'b0;
    link_wdata = '0;
    slot       = '0;
    old_head   = '0;

    case (state_q)
      ST_IDLE: begin
        if (cmd_xfer) begin
          func_d     = cmd_i.func;
          tid_d      = tid_in;
          in_range_d = in_range_in;
          prio_d     = prio_in;
          budget_d   = BUDGET_W'(LEVELS);
          state_d    = (cmd_i.func == FUNC_RESCHEDULE) ? ST_PICK : ST_EXEC;
        end
      end

      ST_EXEC: begin
        res_found_d = 1'b0;
        res_task_d  = '0;
        state_d     = ST_DONE;
        if (in_range_q) begin
          case (func_q)
            FUNC_SCHEDULE: begin
              // A task that is already queued is left alone.
              if (!queued_q[tid_q]) begin
                lvl_we           = 1'b1;
                lvl_set_d[tid_q] = 1'b1;
                if (prio_q < LVLS_W'(LEVELS)) begin
                  push_en  = 1'b1;
                  push_lvl = prio_q;
                end
              end
            end
            FUNC_BLOCK: begin
              if (lvl_set_q[tid_q] && (lvl_rdata != '0)) begin
                blocked_d[tid_q] = 1'b1;
              end
            end
            FUNC_UNBLOCK: begin
              if (blocked_q[tid_q]) begin
                blocked_d[tid_q] = 1'b0;
                if (!queued_q[tid_q] && (lvl_rdata < LVLS_W'(LEVELS))) begin
                  push_en  = 1'b1;
                  push_lvl = lvl_rdata;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_PICK: begin
        if (head_valid_q[rot_q]) begin
          pop_task_d = head_idx_q[rot_q];
          state_d    = ST_POP;
        end else begin
          // Level 0 is empty: rotate the levels down one place.
          rot_d    = (rot_q == LVL_W'(LEVELS - 1)) ? '0 : rot_q + 1'b1;
          budget_d = budget_q - 1'b1;
          if (budget_q == BUDGET_W'(1)) begin
            res_found_d = 1'b0;
            res_task_d  = '0;
            state_d     = ST_DONE;
          end
        end
      end

      ST_POP: begin
        head_valid_d[rot_q] = link_rdata.valid;
        head_idx_d[rot_q]   = link_rdata.idx;
        if (blocked_q[pop_task_q] || (lvl_rdata >= LVLS_W'(LEVELS))) begin
          // Blocked or retired: drop it and search again with a fresh budget.
          queued_d[pop_task_q] = 1'b0;
          budget_d             = BUDGET_W'(LEVELS);
          state_d              = ST_PICK;
        end else begin
          push_en     = 1'b1;
          push_task   = pop_task_q;
          push_lvl    = lvl_rdata;
          res_found_d = 1'b1;
          res_task_d  = pop_task_q;
          state_d     = ST_DONE;
        end
      end

      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Push on the head of a level list; the head already reflects a pop above.
    if (push_en) begin
      slot                = level_slot(push_lvl, rot_q);
      old_head.valid      = head_valid_d[slot];
      old_head.idx        = head_idx_d[slot];
      link_we             = 1'b1;
      link_wdata          = old_head;
      head_valid_d[slot]  = 1'b1;
      head_idx_d[slot]    = push_task;
      queued_d[push_task] = 1'b1;
    end
  end

  // Output register takes the result when it is free or being drained.
  always_comb begin
    out_valid_d = out_valid_q;
    out_found_d = out_found_q;
    out_task_d  = out_task_q;
    if ((state_q == ST_DONE) && out_free) begin
      out_valid_d = 1'b1;
      out_found_d = res_found_q;
      out_task_d  = res_task_q;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.found       = out_found_q;
  assign res_o.chosen_task = TASK_ID_W'(out_task_q);

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      rot_q        <= '0;
      budget_q     <= '0;
      out_valid_q  <= 1'b0;
      head_valid_q <= '0;
      blocked_q    <= '0;
      queued_q     <= '0;
      lvl_set_q    <= '0;
    end else begin
      state_q      <= state_d;
      rot_q        <= rot_d;
      budget_q     <= budget_d;
      out_valid_q  <= out_valid_d;
      head_valid_q <= head_valid_d;
      blocked_q    <= blocked_d;
      queued_q     <= queued_d;
      lvl_set_q    <= lvl_set_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    func_q      <= func_d;
    tid_q       <= tid_d;
    in_range_q  <= in_range_d;
    prio_q      <= prio_d;
    pop_task_q  <= pop_task_d;
    res_found_q <= res_found_d;
    res_task_q  <= res_task_d;
    out_found_q <= out_found_d;
    out_task_q  <= out_task_d;
    head_idx_q  <= head_idx_d;
  end

  // A command transfer always starts work.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_xfer |=> (state_q != ST_IDLE))
    else $error("command transfer did not leave idle");

  // The pick loop never runs with an exhausted rotation budget.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PICK) |-> (budget_q != '0))
    else $error("pick loop running with zero budget");

  // A chosen task is back on a list when its result is ready.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_DONE) && res_found_q) |-> queued_q[res_task_q])
    else $error("chosen task is not queued");

  // Only a task with a recorded level can be blocked.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (blocked_q & ~lvl_set_q) == '0)
    else $error("blocked task without a recorded level");

  // A result without a task carries index zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.found) |-> (res_o.chosen_task == '0))
    else $error("empty result with nonzero task index");

endmodule
